// ===== rtl/hte_pkg.sv =====
// Shared types, constants and fixed-point helpers for the homogeneous transform engine.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package hte_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int COORD_W     = 32;
   localparam int OUT_W       = 32;
   localparam int MUL_W       = (WORD_WIDTH > COORD_W) ? WORD_WIDTH : COORD_W;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = PROD_W - FRAC_BITS + 2;
   localparam int MAT_DIM     = 4;
   localparam int MAT_ENTRIES = MAT_DIM * MAT_DIM;
   localparam int DIM_W       = $clog2(MAT_DIM);
   localparam int IDX_W       = $clog2(MAT_ENTRIES);

   localparam logic [IDX_W-1:0] COMPOSE_LAST   = IDX_W'(MAT_ENTRIES - 1);
   localparam logic [IDX_W-1:0] TRANSFORM_LAST = IDX_W'(2);
   localparam logic [DIM_W-1:0] TERM_LAST      = DIM_W'(MAT_DIM - 1);

   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   localparam logic signed [MUL_W-1:0] POINT_ONE = MUL_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      OP_IDENTITY  = 2'd0,
      OP_WRITE     = 2'd1,
      OP_COMPOSE   = 2'd2,
      OP_TRANSFORM = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [DIM_W-1:0]          row;
      logic [DIM_W-1:0]          col;
      logic signed [COORD_W-1:0] entry_value;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      is_vector;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_x;
      logic signed [OUT_W-1:0] out_y;
      logic signed [OUT_W-1:0] out_z;
      logic                    overflow;
   } rsp_type;

   typedef struct packed {
      logic                         sat;
      logic signed [WORD_WIDTH-1:0] word;
   } sat_result_type;

   // Control from the sequencer to the matrix store.
   typedef struct packed {
      logic                         set_identity;
      logic                         write_operand;
      logic [IDX_W-1:0]             operand_idx;
      logic signed [WORD_WIDTH-1:0] operand_value;
      logic                         write_model;
      logic [IDX_W-1:0]             model_idx;
      logic signed [WORD_WIDTH-1:0] model_value;
      logic                         flip_bank;
   } store_ctrl_type;

   function automatic sat_result_type saturate(input logic signed [ACC_W-1:0] v);
      sat_result_type r;
      r.sat  = 1'b0;
      r.word = v[WORD_WIDTH-1:0];
      if (v > SAT_MAX) begin
         r.sat  = 1'b1;
         r.word = SAT_MAX[WORD_WIDTH-1:0];
      end else if (v < SAT_MIN) begin
         r.sat  = 1'b1;
         r.word = SAT_MIN[WORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // Value of one matrix word that holds 1.0, saturated if it does not fit.
   function automatic logic signed [WORD_WIDTH-1:0] one_word();
      sat_result_type r;
      r = saturate(ACC_W'(1) << FRAC_BITS);
      return r.word;
   endfunction

   // A word as it leaves on a 32-bit output field: sign-extended, low bits kept.
   function automatic logic signed [OUT_W-1:0] to_out(input logic signed [WORD_WIDTH-1:0] w);
      logic signed [MUL_W-1:0] e;
      e = MUL_W'(w);
      return e[OUT_W-1:0];
   endfunction

endpackage

// ===== rtl/hte_mac.sv =====
// Shared multiply-accumulate unit: registered product, floor shift and exact sum of four terms.
// Depends on hte_pkg for the word and accumulator widths.
`timescale 1ns / 1ps

module hte_mac
   import hte_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue,
   input  logic                     first,
   input  logic                     last,
   input  logic signed [MUL_W-1:0]  a,
   input  logic signed [MUL_W-1:0]  b,
   output logic                     done,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     valid_ff, valid_in;
   logic                     first_ff, first_in;
   logic                     last_ff, last_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     done_ff, done_in;
   logic signed [PROD_W-1:0] shifted;

   always_comb begin
      prod_in  = a * b;
      valid_in = issue;
      first_in = first;
      last_in  = last;
      // Arithmetic shift floors the product towards minus infinity.
      shifted  = prod_ff >>> FRAC_BITS;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (valid_ff) begin
         acc_in  = (first_ff ? '0 : acc_ff) + ACC_W'(shifted);
         done_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      acc_ff   <= acc_in;
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// ===== rtl/hte_matrix_store.sv =====
// Matrix storage: two model banks (active and shadow for compose) and the operand matrix.
// Depends on hte_pkg for the control struct, word width and identity value.
`timescale 1ns / 1ps

module hte_matrix_store
   import hte_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  store_ctrl_type               ctrl,
   input  logic [IDX_W-1:0]             model_rd_idx,
   input  logic [IDX_W-1:0]             operand_rd_idx,
   output logic signed [WORD_WIDTH-1:0] model_rd_data,
   output logic signed [WORD_WIDTH-1:0] operand_rd_data
);

   logic signed [WORD_WIDTH-1:0] bank0_ff [MAT_ENTRIES];
   logic signed [WORD_WIDTH-1:0] bank1_ff [MAT_ENTRIES];
   logic signed [WORD_WIDTH-1:0] operand_ff [MAT_ENTRIES];
   logic                         sel_ff, sel_in;
   logic signed [WORD_WIDTH-1:0] one_value;

   assign one_value = one_word();
   assign sel_in    = ctrl.flip_bank ? ~sel_ff : sel_ff;

   always_comb begin
      model_rd_data   = sel_ff ? bank1_ff[model_rd_idx] : bank0_ff[model_rd_idx];
      operand_rd_data = operand_ff[operand_rd_idx];
   end

   // The diagonal of a row-major 4x4 matrix is every fifth entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
         for (int i = 0; i < MAT_ENTRIES; i++) begin
            bank0_ff[i]   <= (i % (MAT_DIM + 1) == 0) ? one_value : '0;
            operand_ff[i] <= (i % (MAT_DIM + 1) == 0) ? one_value : '0;
         end
      end else begin
         sel_ff <= sel_in;
         for (int i = 0; i < MAT_ENTRIES; i++) begin
            if (ctrl.set_identity) begin
               if (sel_ff) begin
                  bank1_ff[i] <= (i % (MAT_DIM + 1) == 0) ? one_value : '0;
               end else begin
                  bank0_ff[i] <= (i % (MAT_DIM + 1) == 0) ? one_value : '0;
               end
            end
         end
         if (ctrl.write_model) begin
            if (sel_ff) begin
               bank0_ff[ctrl.model_idx] <= ctrl.model_value;
            end else begin
               bank1_ff[ctrl.model_idx] <= ctrl.model_value;
            end
         end
         if (ctrl.write_operand) begin
            operand_ff[ctrl.operand_idx] <= ctrl.operand_value;
         end
      end
   end

endmodule

// ===== rtl/homogeneous_transform_engine.sv =====
// Top level of the homogeneous transform engine: request decode, sequencer and result register.
// Depends on hte_pkg, hte_mac and hte_matrix_store.
`timescale 1ns / 1ps

// Usage
// Requests arrive on req_valid/req_ready/req_data, each carrying one operation.
// Results leave on rsp_valid/rsp_ready/rsp_data; only a transform request gives one.
// Reset identity and operand entry writes complete when accepted; req_ready stays high.
// A transform issues twelve products into the single shared multiply-accumulate
// unit, one per cycle. A compose issues sixty-four products, and the block is
// ready again once the new model is in place. The one multiplier takes a new
// pair of words each cycle and sums four floored products per output entry.
// Compose writes the new model into a shadow bank and swaps banks at the end,
// so the old model is read throughout.
// Reset (synchronous, active high) loads identity into the model and operand
// matrices and empties the result register. While the receiver stalls, the
// result waits in its register and further requests are still taken; a second
// transform then holds in its last cycle until the register is free.

module homogeneous_transform_engine
   import hte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [IDX_W-1:0]           out_ff, out_in;
   logic [DIM_W-1:0]           term_ff, term_in;
   logic [IDX_W-1:0]           wr_ff, wr_in;
   logic                       ovf_ff, ovf_in;
   logic signed [MUL_W-1:0]    point_ff [MAT_DIM];
   logic signed [MUL_W-1:0]    point_in [MAT_DIM];
   logic signed [OUT_W-1:0]    res_ff [3];
   logic signed [OUT_W-1:0]    res_in [3];
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                         accept;
   logic [IDX_W-1:0]             last_out;
   logic [IDX_W-1:0]             model_rd_idx;
   logic [IDX_W-1:0]             operand_rd_idx;
   logic signed [WORD_WIDTH-1:0] model_rd_data;
   logic signed [WORD_WIDTH-1:0] operand_rd_data;
   logic signed [MUL_W-1:0]      mac_a;
   logic signed [MUL_W-1:0]      mac_b;
   logic                         mac_issue;
   logic                         mac_done;
   logic signed [ACC_W-1:0]      mac_acc;
   sat_result_type               sat_res;
   sat_result_type               entry_sat;
   store_ctrl_type               store_ctrl;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign last_out  = (op_ff == OP_COMPOSE) ? COMPOSE_LAST : TRANSFORM_LAST;
   assign mac_issue = (state_ff == S_RUN);

   // Compose reads old[term][col] and operand[row][term]; a transform reads
   // model[row][term] against the latched point.
   always_comb begin
      if (op_ff == OP_COMPOSE) begin
         model_rd_idx   = {term_ff, out_ff[DIM_W-1:0]};
         operand_rd_idx = {out_ff[IDX_W-1:DIM_W], term_ff};
         mac_b          = MUL_W'(operand_rd_data);
      end else begin
         model_rd_idx   = {out_ff[DIM_W-1:0], term_ff};
         operand_rd_idx = '0;
         mac_b          = point_ff[term_ff];
      end
      mac_a = MUL_W'(model_rd_data);
   end

   assign sat_res   = saturate(mac_acc);
   assign entry_sat = saturate(ACC_W'(req_data.entry_value));

   always_comb begin
      store_ctrl.set_identity  = accept && (req_data.op == OP_IDENTITY);
      store_ctrl.write_operand = accept && (req_data.op == OP_WRITE);
      store_ctrl.operand_idx   = {req_data.row, req_data.col};
      store_ctrl.operand_value = entry_sat.word;
      store_ctrl.write_model   = mac_done && (op_ff == OP_COMPOSE);
      store_ctrl.model_idx     = wr_ff;
      store_ctrl.model_value   = sat_res.word;
      store_ctrl.flip_bank     = (state_ff == S_FINISH) && (op_ff == OP_COMPOSE);
   end

   hte_matrix_store u_store (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (store_ctrl),
      .model_rd_idx    (model_rd_idx),
      .operand_rd_idx  (operand_rd_idx),
      .model_rd_data   (model_rd_data),
      .operand_rd_data (operand_rd_data)
   );

   hte_mac u_mac (
      .clock (clock),
      .reset (reset),
      .issue (mac_issue),
      .first (term_ff == '0),
      .last  (term_ff == TERM_LAST),
      .a     (mac_a),
      .b     (mac_b),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      out_in       = out_ff;
      term_in      = term_ff;
      wr_in        = wr_ff;
      ovf_in       = ovf_ff;
      point_in     = point_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_data.op;
               if (req_data.op == OP_COMPOSE || req_data.op == OP_TRANSFORM) begin
                  state_in    = S_RUN;
                  out_in      = '0;
                  term_in     = '0;
                  wr_in       = '0;
                  ovf_in      = 1'b0;
                  point_in[0] = MUL_W'(req_data.point_x);
                  point_in[1] = MUL_W'(req_data.point_y);
                  point_in[2] = MUL_W'(req_data.point_z);
                  point_in[3] = req_data.is_vector ? '0 : POINT_ONE;
               end
            end
         end
         S_RUN: begin
            term_in = term_ff + 1'b1;
            if (term_ff == TERM_LAST) begin
               out_in = out_ff + 1'b1;
               if (out_ff == last_out) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (mac_done && wr_ff == last_out) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (op_ff == OP_COMPOSE) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_x    = res_ff[0];
               rsp_data_in.out_y    = res_ff[1];
               rsp_data_in.out_z    = res_ff[2];
               rsp_data_in.overflow = ovf_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Finished sums come out of the unit in issue order.
      if (mac_done) begin
         wr_in = wr_ff + 1'b1;
         if (op_ff == OP_TRANSFORM) begin
            res_in[wr_ff[1:0]] = to_out(sat_res.word);
            ovf_in             = ovf_ff | sat_res.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      out_ff      <= out_in;
      term_ff     <= term_in;
      wr_ff       <= wr_in;
      ovf_ff      <= ovf_in;
      point_ff    <= point_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/hte_checker.sv =====
// Port-level checks for the homogeneous transform engine, bound to the top level.
// Depends on hte_pkg for the request and result types and operation codes.
`timescale 1ns / 1ps

module hte_checker
   import hte_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // A result held back by the receiver keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or vanished while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Compose and transform occupy the shared unit, so ready drops once one is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.op == OP_COMPOSE || req_data.op == OP_TRANSFORM)
      |=> !req_ready)
      else $error("ready while a multi-cycle request is in progress");

   // Identity and entry writes finish in the cycle they are taken.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.op == OP_IDENTITY || req_data.op == OP_WRITE)
      |=> req_ready)
      else $error("not ready after a single-cycle request");

   // No result can appear straight after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after a request");

endmodule

bind homogeneous_transform_engine hte_checker u_hte_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
